FILE: hdl/sgb_pkg.sv
// Package for the scaled glyph blitter: controller states, register indexes,
// reset values and datapath widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

  // Default sizes for the top-level parameters, and the scale limit
  localparam int unsigned ATLAS_TEXELS_DEF = 16384;
  localparam int unsigned MAX_CELL_DEF     = 8;
  localparam int unsigned MAX_SCALE        = 8;

  // Field and datapath widths
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;
  localparam int unsigned DIVW      = 20;  // non-negative glyph index bits
  localparam int unsigned IDXW      = 21;  // signed glyph index bits
  localparam int unsigned ADW       = 36;  // full atlas address before range check
  localparam int unsigned CRDW      = 18;  // coordinate bits before saturation

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CHARS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_COLOR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_VERSIONS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE          = 3'd7;

  // Register reset values
  localparam logic [10:0] RST_ATLAS_WIDTH    = 11'd128;
  localparam logic [3:0]  RST_CHAR_WIDTH     = 4'd8;
  localparam logic [3:0]  RST_CHAR_HEIGHT    = 4'd8;
  localparam logic [7:0]  RST_FIRST_CHAR     = 8'd32;
  localparam logic [10:0] RST_TOTAL_CHARS    = 11'd96;
  localparam logic        RST_MULTI_COLOR    = 1'b0;
  localparam logic [7:0]  RST_COLOR_VERSIONS = 8'd1;
  localparam logic [3:0]  RST_SCALE          = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX,
    ST_GPW,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_BASE,
    ST_WALK,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/scaled_glyph_blitter.sv
// Scaled glyph blitter: loads RGBA atlas texels into an internal memory and
// turns drawn characters into a stream of fill squares. Depends on sgb_pkg.
//
// A load word writes one texel; a newline moves the pen. A draw word runs an
// index step, two passes of the shared one-bit-per-cycle divider (glyphs per
// row, then row and column of the glyph), the MUL1, MUL2 and BASE multiply/add
// steps, a walk reading one atlas texel per cycle from the memory port, and a
// drain. A stalled output stalls the walk.
// Reset clears control state and the pen and loads the register reset values;
// atlas contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module scaled_glyph_blitter
  import sgb_pkg::*;
#(
  parameter int unsigned ATLAS_TEXELS = ATLAS_TEXELS_DEF,
  parameter int unsigned MAX_CELL     = MAX_CELL_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 cmd_i,
  input  wire logic                 string_start_i,
  input  wire logic [7:0]           char_code_i,
  input  wire logic signed [15:0]   origin_x_i,
  input  wire logic signed [15:0]   origin_y_i,
  input  wire logic [7:0]           color_r_i,
  input  wire logic [7:0]           color_g_i,
  input  wire logic [7:0]           color_b_i,
  input  wire logic [7:0]           color_a_i,
  input  wire logic [13:0]          texel_addr_i,
  input  wire logic [31:0]          texel_value_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [15:0]        dest_x_o,
  output logic signed [15:0]        dest_y_o,
  output logic [3:0]                square_size_o,
  output logic [31:0]               out_color_o,
  output logic                      last_o
);

  localparam int unsigned AW = $clog2(ATLAS_TEXELS);

  function automatic logic signed [15:0] sat16(input logic signed [CRDW-1:0] v);
    if (v > $signed(CRDW'(32767))) begin
      return 16'sh7fff;
    end else if (v < -$signed(CRDW'(32768))) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // ---------------------------------------------------------------- registers
  logic [10:0] atlas_width_q, total_chars_q;
  logic [3:0]  char_width_q, char_height_q, scale_q;
  logic [7:0]  first_char_q, color_versions_q;
  logic        multi_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q    <= RST_ATLAS_WIDTH;
      char_width_q     <= RST_CHAR_WIDTH;
      char_height_q    <= RST_CHAR_HEIGHT;
      first_char_q     <= RST_FIRST_CHAR;
      total_chars_q    <= RST_TOTAL_CHARS;
      multi_color_q    <= RST_MULTI_COLOR;
      color_versions_q <= RST_COLOR_VERSIONS;
      scale_q          <= RST_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATLAS_WIDTH:    atlas_width_q    <= cfg_data_i;
        REG_CHAR_WIDTH:     char_width_q     <= cfg_data_i[3:0];
        REG_CHAR_HEIGHT:    char_height_q    <= cfg_data_i[3:0];
        REG_FIRST_CHAR:     first_char_q     <= cfg_data_i[7:0];
        REG_TOTAL_CHARS:    total_chars_q    <= cfg_data_i;
        REG_MULTI_COLOR:    multi_color_q    <= cfg_data_i[0];
        REG_COLOR_VERSIONS: color_versions_q <= cfg_data_i[7:0];
        REG_SCALE:          scale_q          <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamped cell size and scale
  logic [3:0] cw, ch, sc;
  logic [7:0] x_step, y_step;

  assign cw = (char_width_q == 4'd0) ? 4'd1 :
              (char_width_q > 4'(MAX_CELL)) ? 4'(MAX_CELL) : char_width_q;
  assign ch = (char_height_q == 4'd0) ? 4'd1 :
              (char_height_q > 4'(MAX_CELL)) ? 4'(MAX_CELL) : char_height_q;
  assign sc = (scale_q == 4'd0) ? 4'd1 :
              (scale_q > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_q;
  assign x_step = {4'd0, cw} * {4'd0, sc};
  assign y_step = {4'd0, ch} * {4'd0, sc};

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;

  logic in_acc, draw_acc, is_nl;
  logic en, issue, flush, div_step, div_last, walk_end;
  logic s1_v_q, p_v_q, o_v_q;
  logic signed [IDXW-1:0] idx_q;
  logic [DIVW-1:0] quo_q, quo_nxt;
  logic [10:0]     rem_q, rem_nxt, dvs_q;
  logic [11:0]     trial;
  logic            ge;
  logic [4:0]      div_cnt_q;
  logic [3:0]      i_q, j_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign draw_acc = in_acc && cmd_i;
  assign is_nl    = char_code_i == NEWLINE_CODE;
  assign en       = !o_v_q || out_ready_i;
  assign div_last = div_cnt_q == 5'(DIVW - 1);
  assign walk_end = (i_q == cw - 4'd1) && (j_q == ch - 4'd1);

  // Restoring divider, one quotient bit per cycle
  assign trial   = {rem_q, quo_q[DIVW-1]};
  assign ge      = trial >= {1'b0, dvs_q};
  assign rem_nxt = ge ? 11'(trial - {1'b0, dvs_q}) : trial[10:0];
  assign quo_nxt = {quo_q[DIVW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (draw_acc && !is_nl) state_d = ST_IDX;
      ST_IDX:   state_d = ST_GPW;
      ST_GPW: begin
        if (div_last) begin
          if (idx_q[IDXW-1] || (quo_nxt[10:0] == 11'd0)) state_d = ST_DRAIN;
          else                                           state_d = ST_DIV;
        end
      end
      ST_DIV:   if (div_last) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_BASE;
      ST_BASE:  state_d = ST_WALK;
      ST_WALK:  if (issue && walk_end) state_d = ST_DRAIN;
      ST_DRAIN: if (flush) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    flush      = 1'b0;
    div_step   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_GPW,
      ST_DIV:   div_step = 1'b1;
      ST_WALK:  issue = en;
      ST_DRAIN: flush = en && !s1_v_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- atlas memory
  logic [31:0] atlas_mem [ATLAS_TEXELS];
  logic [31:0] rdata_q;
  logic [ADW-1:0] addr_q, col_q;
  logic addr_in;

  assign addr_in = addr_q < ADW'(ATLAS_TEXELS);

  always_ff @(posedge clk_i) begin
    if (in_acc && !cmd_i && ({22'd0, texel_addr_i} < ADW'(ATLAS_TEXELS))) begin
      atlas_mem[AW'(texel_addr_i)] <= texel_value_i;
    end
    if (issue && addr_in) begin
      rdata_q <= atlas_mem[addr_q[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [14:0] pen_x_q, pen_y_q, pen_x_eff, pen_y_eff;
  logic [15:0] pen_x_sum, pen_y_sum, nl_sum;
  logic        page_sel;

  assign pen_x_eff = string_start_i ? 15'd0 : pen_x_q;
  assign pen_y_eff = string_start_i ? 15'd0 : pen_y_q;
  assign nl_sum    = {1'b0, pen_y_eff} + {8'd0, y_step};
  assign pen_x_sum = {1'b0, pen_x_q} + {8'd0, x_step};
  assign pen_y_sum = {1'b0, pen_y_q};
  assign page_sel  = multi_color_q && (color_r_i == 8'd0) && (color_g_i == 8'd0) &&
                     (color_b_i == 8'd0) && (color_a_i != 8'd0) &&
                     (color_a_i < color_versions_q);

  logic [7:0]  code_q;
  logic [18:0] page_off_q;
  logic        black_q;
  logic [31:0] caller_q;
  logic signed [CRDW-1:0] ox0_q, oy0_q, dx_q, dy_q;
  logic [DIVW-1:0] q_q;
  logic [10:0]     r_q;
  logic [14:0]     cx_q;
  logic [23:0]     cy_q;
  logic [34:0]     prod_q;

  logic signed [CRDW-1:0] s1_dx_q, s1_dy_q;
  logic                   s1_in_q;
  logic signed [15:0]     p_x_q, p_y_q;
  logic [31:0]            p_color_q;
  logic                   opaque, take_s1, o_load;

  assign opaque  = s1_in_q && (rdata_q[7:0] != 8'd0);
  assign take_s1 = en && s1_v_q && opaque;
  assign o_load  = p_v_q && (take_s1 || flush);

  // Control state and pen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      p_v_q     <= 1'b0;
      o_v_q     <= 1'b0;
      pen_x_q   <= '0;
      pen_y_q   <= '0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_IDX || (state_q == ST_GPW && div_last)) div_cnt_q <= '0;
      else if (div_step)                                        div_cnt_q <= div_cnt_q + 5'd1;

      if (en) s1_v_q <= issue;

      if (take_s1)    p_v_q <= 1'b1;
      else if (flush) p_v_q <= 1'b0;

      if (o_load)           o_v_q <= 1'b1;
      else if (out_ready_i) o_v_q <= 1'b0;

      if (draw_acc) begin
        if (is_nl) begin
          pen_x_q <= '0;
          pen_y_q <= nl_sum[15] ? 15'h7fff : nl_sum[14:0];
        end else begin
          pen_x_q <= pen_x_eff;
          pen_y_q <= pen_y_eff;
        end
      end else if (flush) begin
        pen_x_q <= pen_x_sum[15] ? 15'h7fff : pen_x_sum[14:0];
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      code_q     <= char_code_i;
      page_off_q <= page_sel ? 19'({8'd0, color_a_i - 8'd1} * {8'd0, total_chars_q}) : '0;
      black_q    <= (color_r_i == 8'd0) && (color_g_i == 8'd0) && (color_b_i == 8'd0);
      caller_q   <= {color_r_i, color_g_i, color_b_i, color_a_i};
      ox0_q      <= CRDW'(origin_x_i) + $signed({3'd0, pen_x_eff});
      oy0_q      <= CRDW'(origin_y_i) + $signed({3'd0, pen_y_eff});
      // glyphs per atlas row: atlas_width / cw
      quo_q      <= {9'd0, atlas_width_q};
      rem_q      <= '0;
      dvs_q      <= {7'd0, cw};
    end

    case (state_q)
      ST_IDX: begin
        idx_q <= $signed({2'd0, page_off_q}) + $signed({13'd0, code_q})
                 - $signed({13'd0, first_char_q});
      end
      ST_GPW: begin
        if (div_last) begin
          quo_q <= idx_q[DIVW-1:0];
          rem_q <= '0;
          dvs_q <= quo_nxt[10:0];
        end else begin
          quo_q <= quo_nxt;
          rem_q <= rem_nxt;
        end
      end
      ST_DIV: begin
        quo_q <= quo_nxt;
        rem_q <= rem_nxt;
        if (div_last) begin
          q_q <= quo_nxt;
          r_q <= rem_nxt;
        end
      end
      ST_MUL1: begin
        cx_q <= {4'd0, r_q} * {11'd0, cw};
        cy_q <= {4'd0, q_q} * {20'd0, ch};
      end
      ST_MUL2: begin
        prod_q <= {11'd0, cy_q} * {24'd0, atlas_width_q};
      end
      ST_BASE: begin
        addr_q <= ADW'(prod_q) + ADW'(cx_q);
        col_q  <= ADW'(prod_q) + ADW'(cx_q);
        i_q    <= '0;
        j_q    <= '0;
        dx_q   <= ox0_q;
        dy_q   <= oy0_q;
      end
      ST_WALK: begin
        if (issue) begin
          if (j_q == ch - 4'd1) begin
            // advance to the top of the next column
            j_q    <= '0;
            i_q    <= i_q + 4'd1;
            col_q  <= col_q + ADW'(1);
            addr_q <= col_q + ADW'(1);
            dx_q   <= dx_q + $signed({14'd0, sc});
            dy_q   <= oy0_q;
          end else begin
            j_q    <= j_q + 4'd1;
            addr_q <= addr_q + ADW'(atlas_width_q);
            dy_q   <= dy_q + $signed({14'd0, sc});
          end
        end
      end
      default: ;
    endcase

    if (en) begin
      s1_dx_q <= dx_q;
      s1_dy_q <= dy_q;
      s1_in_q <= addr_in;
    end

    // Hold the newest opaque square back one step so the final one can carry last
    if (take_s1) begin
      p_x_q     <= sat16(s1_dx_q);
      p_y_q     <= sat16(s1_dy_q);
      p_color_q <= (!multi_color_q && black_q) ? caller_q : rdata_q;
    end

    if (o_load) begin
      dest_x_o      <= p_x_q;
      dest_y_o      <= p_y_q;
      square_size_o <= sc;
      out_color_o   <= p_color_q;
      last_o        <= flush;
    end
  end

  assign out_valid_o = o_v_q;

  // pen_y passes through unchanged at the end of a character
  logic unused_pen_y;
  assign unused_pen_y = pen_y_sum[15];

endmodule

`default_nettype wire
